### rtl/signed_integer_literal_parser_unit_macros.svh
`ifndef SIGNED_INTEGER_LITERAL_PARSER_UNIT_MACROS_SVH
`define SIGNED_INTEGER_LITERAL_PARSER_UNIT_MACROS_SVH

// same-cycle implication, checked on clk, off during reset
`define SILP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define SILP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/silp_pkg.sv
package silp_pkg;

  typedef enum logic [2:0] {
    PH_DONE   = 3'd0,
    PH_START  = 3'd1,
    PH_SIGNED = 3'd2,
    PH_ZERO   = 3'd3,
    PH_HEX    = 3'd4,
    PH_QUOTE  = 3'd5,
    PH_DEC    = 3'd6
  } phase_t;

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] HEX_TEN  = 8'd10;

  typedef struct packed {
    logic        valid;
    logic [31:0] value;
  } res_t;

endpackage

### rtl/silp_core.sv
`include "signed_integer_literal_parser_unit_macros.svh"

module silp_core import silp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic       step_en,
  input  logic [7:0] ch,
  input  logic       first,
  output res_t       res
);

  phase_t      phase, phase_next;
  logic        negative, negative_next;
  logic [31:0] acc, acc_next;

  always_comb begin
    phase_t      ph;
    logic        neg;
    logic [31:0] a;
    logic [31:0] fin;
    logic        fin_en;
    logic        dec_ok;
    logic        hex_ok;
    logic [3:0]  hex_d;
    logic [31:0] acc_dec;

    ph  = phase;
    neg = negative;
    a   = acc;
    if (first) begin
      ph  = PH_START;
      neg = 1'b0;
      a   = '0;
    end

    dec_ok  = (ch inside {[CH_0:CH_9]});
    acc_dec = (a << 3) + (a << 1) + {28'd0, ch[3:0]};

    hex_ok = 1'b1;
    hex_d  = ch[3:0];
    if (ch inside {[CH_LA:CH_LF]}) begin
      hex_d = 4'(ch - CH_LA + HEX_TEN);
    end else if (ch inside {[CH_UA:CH_UF]}) begin
      hex_d = 4'(ch - CH_UA + HEX_TEN);
    end else if (!dec_ok) begin
      hex_ok = 1'b0;
    end

    phase_next    = ph;
    negative_next = neg;
    acc_next      = a;
    fin_en        = 1'b0;
    fin           = a;

    case (ph)
      PH_START, PH_SIGNED: begin
        if (ph == PH_START && ch == CH_MINUS) begin
          negative_next = 1'b1;
          phase_next    = PH_SIGNED;
        end else if (ch == CH_0) begin
          phase_next = PH_ZERO;
        end else if (ch == CH_QUOTE) begin
          phase_next = PH_QUOTE;
        end else if (dec_ok) begin
          acc_next   = acc_dec;
          phase_next = PH_DEC;
        end else begin
          fin_en = 1'b1;
        end
      end
      PH_ZERO: begin
        if (ch == CH_LX || ch == CH_UX) begin
          phase_next = PH_HEX;
        end else if (dec_ok) begin
          acc_next   = acc_dec;
          phase_next = PH_DEC;
        end else begin
          fin_en = 1'b1;
        end
      end
      PH_DEC: begin
        if (dec_ok) begin
          acc_next = acc_dec;
        end else begin
          fin_en = 1'b1;
        end
      end
      PH_HEX: begin
        if (hex_ok) begin
          acc_next = {a[27:0], hex_d};
        end else begin
          fin_en = 1'b1;
        end
      end
      PH_QUOTE: begin
        fin    = {24'd0, ch};
        fin_en = 1'b1;
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase

    if (fin_en) begin
      phase_next = PH_DONE;
    end

    res.valid = item_valid && fin_en;
    res.value = neg ? (32'd0 - fin) : fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_DONE;
      negative <= 1'b0;
      acc      <= '0;
    end else if (step_en) begin
      phase    <= phase_next;
      negative <= negative_next;
      acc      <= acc_next;
    end
  end

  `SILP_ASSERT_NEXT(a_finish_to_done, step_en && res.valid, phase == PH_DONE, "finish did not return to done")
  `SILP_ASSERT_NOW(a_quote_finishes, item_valid && !first && phase == PH_QUOTE, res.valid, "quoted character gave no result")
  `SILP_ASSERT_NOW(a_done_silent, item_valid && !first && phase == PH_DONE, !res.valid, "result after end of number")

endmodule

### rtl/silp_out_reg.sv
module silp_out_reg import silp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  res_t        res,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [31:0] out_value,
  output logic        free
);

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= res.valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_value <= res.value;
    end
  end

endmodule

### rtl/signed_integer_literal_parser_unit.sv
// A result is offered once the character that ends the number has passed the input register,
// the parse step and the result register. Throughput: one character per cycle while not stalled.
// A result waiting under stall does not block the next character unless it also ends a number.
// Reset (rst, synchronous): input and result registers empty, parser done and awaiting a
// first character, sign and accumulated value cleared.
module signed_integer_literal_parser_unit import silp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         ch,
  input  logic               first,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] value
);

  logic        in_full;
  logic [7:0]  ch_r;
  logic        first_r;
  logic        advance;
  logic        accept;
  logic        free;
  logic [31:0] out_value;
  res_t        res;

  assign advance  = in_full && (!res.valid || free);
  assign in_stall = in_full && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r    <= ch;
      first_r <= first;
    end
  end

  silp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (in_full),
    .step_en    (advance),
    .ch         (ch_r),
    .first      (first_r),
    .res        (res)
  );

  silp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res.valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_value (out_value),
    .free      (free)
  );

  assign value = signed'(out_value);

endmodule

### verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import silp_pkg::*;

  typedef struct {
    logic [7:0]  c;
    logic        f;
    bit          fixed;
    logic [31:0] v;
  } lit_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         ch;
  logic               first;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] value;

  phase_t      lit_phase;
  logic        lit_neg;
  logic [31:0] lit_acc;

  logic signed [31:0] pending_values[$];
  int send_idle_pct;
  int stall_pct;
  int n_fail;
  int n_chars;
  int n_values;
  int n_strings;
  int n_lit_chars;

  lit_row_t dir_rows[24] = '{
    '{"Z",       1'b0, 1'b0, 32'd0},
    '{"7",       1'b1, 1'b0, 32'd0},
    '{";",       1'b0, 1'b1, 32'd7},
    '{"q",       1'b0, 1'b0, 32'd0},
    '{CH_MINUS,  1'b1, 1'b0, 32'd0},
    '{CH_0,      1'b0, 1'b0, 32'd0},
    '{CH_UX,     1'b0, 1'b0, 32'd0},
    '{CH_LF,     1'b0, 1'b0, 32'd0},
    '{CH_UF,     1'b0, 1'b0, 32'd0},
    '{" ",       1'b0, 1'b1, -32'sd255},
    '{CH_QUOTE,  1'b1, 1'b0, 32'd0},
    '{8'hff,     1'b0, 1'b1, 32'd255},
    '{CH_MINUS,  1'b1, 1'b0, 32'd0},
    '{CH_QUOTE,  1'b0, 1'b0, 32'd0},
    '{8'h00,     1'b0, 1'b1, 32'd0},
    '{CH_0,      1'b1, 1'b0, 32'd0},
    '{CH_9,      1'b0, 1'b0, 32'd0},
    '{8'hff,     1'b0, 1'b0, 32'd0},
    '{"1",       1'b1, 1'b0, 32'd0},
    '{"2",       1'b0, 1'b0, 32'd0},
    '{"4",       1'b1, 1'b0, 32'd0},
    '{8'h00,     1'b0, 1'b1, 32'd4},
    '{CH_MINUS,  1'b1, 1'b0, 32'd0},
    '{CH_LA,     1'b0, 1'b1, 32'd0}
  };

  signed_integer_literal_parser_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .ch        (ch),
    .first     (first),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value)
  );

  always #1 clk = ~clk;

  function automatic bit decimal_digit(input logic [7:0] c);
    if (c < CH_0 || c > CH_9) begin
      return 1'b1;
    end
    lit_acc = lit_acc * 32'(HEX_TEN) + 32'(c - CH_0);
    lit_phase = PH_DEC;
    return 1'b0;
  endfunction

  function automatic bit parse_char(input logic [7:0] c, input logic f,
                                    output logic [31:0] v);
    logic [3:0] d;
    bit ends;
    ends = 1'b0;
    v = '0;
    d = '0;
    if (f) begin
      lit_phase = PH_START;
      lit_neg = 1'b0;
      lit_acc = '0;
    end
    case (lit_phase)
      PH_START, PH_SIGNED: begin
        if (lit_phase == PH_START && c == CH_MINUS) begin
          lit_neg = 1'b1;
          lit_phase = PH_SIGNED;
        end else if (c == CH_0) begin
          lit_phase = PH_ZERO;
        end else if (c == CH_QUOTE) begin
          lit_phase = PH_QUOTE;
        end else begin
          ends = decimal_digit(c);
        end
      end
      PH_ZERO: begin
        if (c == CH_LX || c == CH_UX) begin
          lit_phase = PH_HEX;
        end else begin
          ends = decimal_digit(c);
        end
      end
      PH_HEX: begin
        if (c >= CH_0 && c <= CH_9) begin
          d = 4'(c - CH_0);
        end else if (c >= CH_LA && c <= CH_LF) begin
          d = 4'(c - CH_LA + HEX_TEN);
        end else if (c >= CH_UA && c <= CH_UF) begin
          d = 4'(c - CH_UA + HEX_TEN);
        end else begin
          ends = 1'b1;
        end
        if (!ends) begin
          lit_acc = {lit_acc[27:0], d};
        end
      end
      PH_QUOTE: begin
        lit_acc = {24'd0, c};
        ends = 1'b1;
      end
      PH_DEC: ends = decimal_digit(c);
      default: lit_phase = PH_DONE;
    endcase
    if (ends) begin
      v = lit_neg ? -lit_acc : lit_acc;
      lit_phase = PH_DONE;
    end
    return ends;
  endfunction

  // call at a falling edge; returns at the falling edge after the transaction
  task automatic send_char(input logic [7:0] c, input logic f,
                           input bit fixed, input logic [31:0] fixed_v);
    logic [31:0] v;
    bit got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    ch = c;
    first = f;
    do @(posedge clk); while (in_stall);
    got = parse_char(c, f, v);
    if (fixed) begin
      pending_values.push_back(fixed_v);
    end else if (got) begin
      pending_values.push_back(v);
    end
    n_chars++;
    @(negedge clk);
  endtask

  task automatic send_literal();
    logic [7:0] s[$];
    logic [7:0] b;
    int n;
    int form;
    if ($urandom_range(2) == 0) begin
      s.push_back(CH_MINUS);
    end
    form = $urandom_range(9);
    if (form < 4) begin
      s.push_back(CH_0);
      s.push_back($urandom_range(1) ? CH_LX : CH_UX);
      n = $urandom_range(10);
      repeat (n) begin
        b = 8'($urandom_range(15));
        if (b < 10) begin
          s.push_back(CH_0 + b);
        end else begin
          s.push_back(($urandom_range(1) ? CH_LA : CH_UA) + b - HEX_TEN);
        end
      end
    end else if (form < 6) begin
      s.push_back(CH_QUOTE);
      s.push_back(8'($urandom_range(255)));
    end else begin
      n = $urandom_range(12);
      repeat (n) s.push_back(CH_0 + 8'($urandom_range(9)));
    end
    s.push_back(8'($urandom_range(255)));
    n = $urandom_range(3);
    repeat (n) s.push_back(8'($urandom_range(255)));
    if ($urandom_range(19) == 0) begin
      s = s[0:$urandom_range(s.size() - 1)];
    end
    foreach (s[i]) begin
      send_char(s[i], i == 0, 1'b0, '0);
    end
    n_lit_chars += s.size();
    n_strings++;
  endtask

  always @(negedge clk) begin
    out_stall = !rst && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_values.size() == 0) begin
        $error("value: nothing expected, actual %0d", value);
        n_fail++;
      end else begin
        if (value !== pending_values[0]) begin
          $error("value: expected %0d, actual %0d", pending_values[0], value);
          n_fail++;
        end
        void'(pending_values.pop_front());
        n_values++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("signed_integer_literal_parser_unit: mismatch");
    $finish;
  end

  initial begin
    int q;
    rst = 1'b1;
    in_valid = 1'b0;
    ch = '0;
    first = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    lit_phase = PH_DONE;
    lit_neg = 1'b0;
    lit_acc = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      send_char(dir_rows[i].c, dir_rows[i].f, dir_rows[i].fixed, dir_rows[i].v);
    end

    while (n_lit_chars < 1400) begin
      q = n_lit_chars * 4 / 1400;
      send_idle_pct = (q == 1) ? 77 : (q == 3) ? 18 : 0;
      stall_pct     = (q == 2) ? 77 : (q == 3) ? 18 : 0;
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send_char(8'($urandom_range(255)), $urandom_range(7) == 0, 1'b0, '0);
        end
      end else begin
        send_literal();
      end
    end
    in_valid = 1'b0;

    while (pending_values.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d characters in %0d random strings plus a directed table", n_chars, n_strings);
    $display("%0d values checked across idle, sender-gap, stall and mixed phases", n_values);
    if (n_fail == 0) begin
      $display("signed_integer_literal_parser_unit: match");
    end else begin
      $display("signed_integer_literal_parser_unit: mismatch");
    end
    $finish;
  end

endmodule
